// ===== src/pixel_hue_saturation_adjust_defines.svh =====
// Assertion macros shared by the pixel adjust RTL.
`ifndef PIXEL_HUE_SATURATION_ADJUST_DEFINES_SVH
`define PIXEL_HUE_SATURATION_ADJUST_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define PHSA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define PHSA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/phsa_pkg.sv =====
// Shared types, widths and tables for the pixel hue/saturation adjust pipeline.
`default_nettype none

package phsa_pkg;

    localparam int CH_W          = 15;
    localparam int GAIN_W        = 17;
    localparam int BRIGHT_W      = 20;
    localparam int HUE_W         = 19;
    localparam int SAT_W         = 16;
    localparam int CFG_W         = 20;
    localparam int FRAC_W        = 16;
    localparam int H_W           = 20;
    localparam int DIV_STEPS     = FRAC_W;
    localparam int DIV_PER_STAGE = 2;
    localparam int DIV_STAGES    = DIV_STEPS / DIV_PER_STAGE;
    localparam int TONE_SHIFT    = 12;
    localparam int PROD_W        = CH_W + 1 + GAIN_W;
    localparam int CH_MAX        = 32767;
    localparam int LANES         = 4;

    typedef logic [CH_W-1:0] chan_t;

    typedef enum logic [1:0] {
        CFG_CONTRAST = 2'd0,
        CFG_BRIGHT   = 2'd1,
        CFG_HUE      = 2'd2,
        CFG_SAT      = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SEC_GREEN = 2'd1,
        SEC_RED   = 2'd2,
        SEC_BLUE  = 2'd3
    } sector_t;

    typedef enum logic [1:0] {
        VSEL_ZERO = 2'd0,
        VSEL_S    = 2'd1,
        VSEL_UP   = 2'd2,
        VSEL_DOWN = 2'd3
    } vsel_t;

    typedef struct packed {
        logic          valid;
        chan_t         mx;
        chan_t         s;
        chan_t         a;
        sector_t       sec;
        logic          d_neg;
        chan_t         d_abs;
        logic [CH_W:0] den;
    } front_t;

    typedef struct packed {
        chan_t   mx;
        chan_t   s;
        chan_t   a;
        sector_t sec;
    } side_t;

    typedef struct packed {
        logic              valid;
        side_t             side;
        logic              neg;
        logic [FRAC_W-1:0] quo;
    } quot_t;

    typedef struct packed {
        logic  valid;
        chan_t r;
        chan_t g;
        chan_t b;
        chan_t a;
    } pix_t;

    // Reduce a sector count 0..15 to 0..5.
    function automatic logic [2:0] mod6(input logic [3:0] x);
        logic [3:0] r;
        begin
            r = x;
            if (r >= 4'd12)
                r = r - 4'd12;
            else if (r >= 4'd6)
                r = r - 4'd6;
            return r[2:0];
        end
    endfunction

    // Which term is subtracted from the maximum in each hue sector.
    function automatic vsel_t sector_sel(input logic [2:0] i);
        vsel_t v;
        begin
            case (i)
                3'd0:    v = VSEL_S;
                3'd1:    v = VSEL_S;
                3'd2:    v = VSEL_DOWN;
                3'd3:    v = VSEL_ZERO;
                3'd4:    v = VSEL_ZERO;
                3'd5:    v = VSEL_UP;
                default: v = VSEL_ZERO;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

// ===== src/phsa_front.sv =====
// Front stages: channel max/min, hue sector and chroma scaled by saturation.
`default_nettype none
`include "pixel_hue_saturation_adjust_defines.svh"

module phsa_front
    import phsa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    input  wire chan_t                   r,
    input  wire chan_t                   g,
    input  wire chan_t                   b,
    input  wire chan_t                   a,
    input  wire logic signed [SAT_W-1:0] sat_gain,
    output front_t                       out
);

    // stage 1
    logic                 v1_reg;
    chan_t                mx1_reg, mn1_reg, a1_reg;
    sector_t              sec1_reg;
    logic signed [CH_W:0] d1_reg;
    chan_t                mx1_next, mn1_next;
    sector_t              sec1_next;
    logic signed [CH_W:0] d1_next;

    // stage 2
    logic                 v2_reg;
    chan_t                mx2_reg, a2_reg, dabs2_reg, base2_reg;
    sector_t              sec2_reg;
    logic                 dneg2_reg;
    logic [CH_W:0]        den2_reg;
    logic [2*CH_W-1:0]    p2_reg;
    chan_t                s0, opa, base2_next, dabs2_next;
    logic [CH_W:0]        dmag;
    logic [2*CH_W-1:0]    p2_next;

    // stage 3
    logic                 v3_reg;
    chan_t                mx3_reg, a3_reg, dabs3_reg, s3_reg;
    sector_t              sec3_reg;
    logic                 dneg3_reg;
    logic [CH_W:0]        den3_reg;
    logic [CH_W:0]        s_sum;

    always_comb
    begin
        mx1_next = r;
        mn1_next = r;
        if (g < mn1_next) mn1_next = g;
        if (g > mx1_next) mx1_next = g;
        if (b < mn1_next) mn1_next = b;
        if (b > mx1_next) mx1_next = b;
        if (b == mx1_next)
        begin
            sec1_next = SEC_BLUE;
            d1_next   = $signed({1'b0, g}) - $signed({1'b0, r});
        end
        else if (g == mx1_next)
        begin
            sec1_next = SEC_GREEN;
            d1_next   = $signed({1'b0, r}) - $signed({1'b0, b});
        end
        else
        begin
            sec1_next = SEC_RED;
            d1_next   = $signed({1'b0, b}) - $signed({1'b0, g});
        end
    end

    // Negative gain scales the chroma down; positive pulls the minimum toward zero.
    assign s0         = mx1_reg - mn1_reg;
    assign opa        = sat_gain[SAT_W-1] ? s0 : mn1_reg;
    assign base2_next = sat_gain[SAT_W-1] ? '0 : s0;
    assign p2_next    = opa * sat_gain[SAT_W-2:0];
    assign dmag       = d1_reg[CH_W] ? (-d1_reg) : d1_reg;
    assign dabs2_next = dmag[CH_W-1:0];

    assign s_sum = {1'b0, base2_reg} + {1'b0, p2_reg[2*CH_W-1:CH_W]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mx1_reg   <= mx1_next;
        mn1_reg   <= mn1_next;
        a1_reg    <= a;
        sec1_reg  <= sec1_next;
        d1_reg    <= d1_next;

        mx2_reg   <= mx1_reg;
        a2_reg    <= a1_reg;
        sec2_reg  <= sec1_reg;
        dneg2_reg <= d1_reg[CH_W];
        dabs2_reg <= dabs2_next;
        den2_reg  <= {1'b0, s0} + {{CH_W{1'b0}}, 1'b1};
        p2_reg    <= p2_next;
        base2_reg <= base2_next;

        mx3_reg   <= mx2_reg;
        a3_reg    <= a2_reg;
        sec3_reg  <= sec2_reg;
        dneg3_reg <= dneg2_reg;
        dabs3_reg <= dabs2_reg;
        den3_reg  <= den2_reg;
        s3_reg    <= s_sum[CH_W-1:0];
    end

    assign out.valid = v3_reg;
    assign out.mx    = mx3_reg;
    assign out.s     = s3_reg;
    assign out.a     = a3_reg;
    assign out.sec   = sec3_reg;
    assign out.d_neg = dneg3_reg;
    assign out.d_abs = dabs3_reg;
    assign out.den   = den3_reg;

    `PHSA_ASSERT_NOW(a_front_s_le_max, v3_reg, s3_reg <= mx3_reg, "scaled chroma above channel maximum")

    `PHSA_ASSERT_NOW(a_front_d_lt_den, v3_reg, {1'b0, dabs3_reg} < den3_reg, "hue difference not below divisor")

endmodule

`default_nettype wire

// ===== src/phsa_div.sv =====
// Pipelined restoring divider for the hue fraction, two quotient bits per stage.
`default_nettype none
`include "pixel_hue_saturation_adjust_defines.svh"

module phsa_div
    import phsa_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire front_t in,
    output quot_t       out
);

    logic              valid_reg [DIV_STAGES];
    side_t             side_reg  [DIV_STAGES];
    logic              neg_reg   [DIV_STAGES];
    logic [CH_W:0]     rem_reg   [DIV_STAGES];
    logic [CH_W:0]     den_reg   [DIV_STAGES];
    logic [FRAC_W-1:0] quo_reg   [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_stage
        logic              valid_src;
        side_t             side_src;
        logic              neg_src;
        logic [CH_W:0]     rem_src, den_src, rem_next;
        logic [FRAC_W-1:0] quo_src, quo_next;

        if (k == 0)
        begin : g_first
            // Remainder starts at |d|, already below the divisor.
            assign valid_src = in.valid;
            assign side_src  = '{mx: in.mx, s: in.s, a: in.a, sec: in.sec};
            assign neg_src   = in.d_neg;
            assign rem_src   = {1'b0, in.d_abs};
            assign den_src   = in.den;
            assign quo_src   = '0;
        end
        else
        begin : g_rest
            assign valid_src = valid_reg[k-1];
            assign side_src  = side_reg[k-1];
            assign neg_src   = neg_reg[k-1];
            assign rem_src   = rem_reg[k-1];
            assign den_src   = den_reg[k-1];
            assign quo_src   = quo_reg[k-1];
        end

        always_comb
        begin
            logic [CH_W+1:0] t;
            logic [CH_W+1:0] diff;
            rem_next = rem_src;
            quo_next = quo_src;
            for (int j = 0; j < DIV_PER_STAGE; j++)
            begin
                t    = {rem_next, 1'b0};
                diff = t - {1'b0, den_src};
                if (t >= {1'b0, den_src})
                begin
                    rem_next = diff[CH_W:0];
                    quo_next = {quo_next[FRAC_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = t[CH_W:0];
                    quo_next = {quo_next[FRAC_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else
                valid_reg[k] <= valid_src;
        end

        always_ff @(posedge clk)
        begin
            side_reg[k] <= side_src;
            neg_reg[k]  <= neg_src;
            rem_reg[k]  <= rem_next;
            den_reg[k]  <= den_src;
            quo_reg[k]  <= quo_next;
        end
    end

    assign out.valid = valid_reg[DIV_STAGES-1];
    assign out.side  = side_reg[DIV_STAGES-1];
    assign out.neg   = neg_reg[DIV_STAGES-1];
    assign out.quo   = quo_reg[DIV_STAGES-1];

    `PHSA_ASSERT_NOW(a_div_rem_lt_den, valid_reg[DIV_STAGES-1], rem_reg[DIV_STAGES-1] < den_reg[DIV_STAGES-1], "divider remainder not below divisor")

endmodule

`default_nettype wire

// ===== src/phsa_rebuild.sv =====
// Hue stages: hue sum with offset, sector fraction product, RGB rebuild from the sector table.
`default_nettype none
`include "pixel_hue_saturation_adjust_defines.svh"

module phsa_rebuild
    import phsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire quot_t            in,
    input  wire logic [HUE_W-1:0] hue_offset,
    output pix_t                  out
);

    // stage 1
    logic                   v1_reg;
    side_t                  side1_reg;
    logic [2:0]             i1_reg;
    logic [FRAC_W-1:0]      fh1_reg;
    logic signed [FRAC_W:0] q;
    logic signed [H_W:0]    h_full;
    logic [H_W-1:0]         h;

    // stage 2
    logic                   v2_reg;
    side_t                  side2_reg;
    logic [2:0]             i2_reg;
    logic [CH_W+FRAC_W-1:0] p2_reg;

    // stage 3
    logic                   v3_reg;
    chan_t                  r3_reg, g3_reg, b3_reg, a3_reg, mx3_reg;
    chan_t                  up, down, r3_next, g3_next, b3_next;
    logic [2:0]             ig, ib;

    function automatic chan_t pick(input vsel_t sel, input chan_t s, input chan_t u,
                                   input chan_t dn);
        chan_t v;
        begin
            case (sel)
                VSEL_ZERO: v = '0;
                VSEL_S:    v = s;
                VSEL_UP:   v = u;
                VSEL_DOWN: v = dn;
                default:   v = '0;
            endcase
            return v;
        end
    endfunction

    // Quotient is truncated toward zero, so negate the magnitude.
    assign q      = in.neg ? -$signed({1'b0, in.quo}) : $signed({1'b0, in.quo});
    assign h_full = $signed({2'b00, in.side.sec, {(FRAC_W+1){1'b0}}})
                  + $signed({2'b00, hue_offset})
                  + {{(H_W-FRAC_W){q[FRAC_W]}}, q};
    assign h      = h_full[H_W-1:0];

    assign up   = p2_reg[CH_W+FRAC_W-1:FRAC_W];
    assign down = side2_reg.s - up - {{(CH_W-1){1'b0}}, (p2_reg[FRAC_W-1:0] != '0)};
    assign ig   = mod6({1'b0, i2_reg} + 4'd2);
    assign ib   = mod6({1'b0, i2_reg} + 4'd4);

    always_comb
    begin
        if (side2_reg.s == '0)
        begin
            r3_next = side2_reg.mx;
            g3_next = side2_reg.mx;
            b3_next = side2_reg.mx;
        end
        else
        begin
            r3_next = side2_reg.mx - pick(sector_sel(i2_reg), side2_reg.s, up, down);
            g3_next = side2_reg.mx - pick(sector_sel(ig), side2_reg.s, up, down);
            b3_next = side2_reg.mx - pick(sector_sel(ib), side2_reg.s, up, down);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= in.side;
        i1_reg    <= mod6(h[H_W-1:FRAC_W]);
        fh1_reg   <= h[FRAC_W-1:0];

        side2_reg <= side1_reg;
        i2_reg    <= i1_reg;
        p2_reg    <= side1_reg.s * fh1_reg;

        r3_reg    <= r3_next;
        g3_reg    <= g3_next;
        b3_reg    <= b3_next;
        a3_reg    <= side2_reg.a;
        mx3_reg   <= side2_reg.mx;
    end

    assign out.valid = v3_reg;
    assign out.r     = r3_reg;
    assign out.g     = g3_reg;
    assign out.b     = b3_reg;
    assign out.a     = a3_reg;

    `PHSA_ASSERT_NEXT(a_rebuild_advance, in.valid, v1_reg, "hue stage dropped a transaction")

    // Every sector leaves one channel at the maximum.
    `PHSA_ASSERT_NOW(a_rebuild_keeps_max, v3_reg, (r3_reg == mx3_reg) || (g3_reg == mx3_reg) || (b3_reg == mx3_reg), "no rebuilt channel at maximum")

endmodule

`default_nettype wire

// ===== src/phsa_tone.sv =====
// Contrast, brightness and clamp on all four channels.
`default_nettype none

module phsa_tone
    import phsa_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire pix_t                       in,
    input  wire logic signed [GAIN_W-1:0]   contrast_gain,
    input  wire logic signed [BRIGHT_W-1:0] brightness_offset,
    output pix_t                            out
);

    localparam int SH_W  = PROD_W - TONE_SHIFT;
    localparam int SUM_W = SH_W + 1;

    chan_t                    lane_in  [LANES];
    logic signed [PROD_W-1:0] prod_reg [LANES];
    chan_t                    res_next [LANES];
    chan_t                    res_reg  [LANES];
    logic                     v1_reg, v2_reg;

    assign lane_in[0] = in.r;
    assign lane_in[1] = in.g;
    assign lane_in[2] = in.b;
    assign lane_in[3] = in.a;

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        logic signed [SH_W-1:0]  sh;
        logic signed [SUM_W-1:0] sum;

        // Arithmetic shift floors toward minus infinity.
        assign sh  = prod_reg[k][PROD_W-1:TONE_SHIFT];
        assign sum = {sh[SH_W-1], sh}
                   + {{(SUM_W-BRIGHT_W){brightness_offset[BRIGHT_W-1]}}, brightness_offset};

        always_comb
        begin
            if (sum < 0)
                res_next[k] = '0;
            else if (sum > CH_MAX)
                res_next[k] = chan_t'(CH_MAX);
            else
                res_next[k] = sum[CH_W-1:0];
        end

        always_ff @(posedge clk)
        begin
            prod_reg[k] <= $signed({1'b0, lane_in[k]}) * contrast_gain;
            res_reg[k]  <= res_next[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in.valid;
            v2_reg <= v1_reg;
        end
    end

    assign out.valid = v2_reg;
    assign out.r     = res_reg[0];
    assign out.g     = res_reg[1];
    assign out.b     = res_reg[2];
    assign out.a     = res_reg[3];

endmodule

`default_nettype wire

// ===== src/pixel_hue_saturation_adjust.sv =====
// Top level of the RGBA hue, saturation, contrast and brightness pipeline.
//
//   channel   handshake          payload
//   ------------------------------------------------------------------
//   pixel in  start / busy       red_in, green_in, blue_in, alpha_in
//   pixel out done (1 cycle)     red_out, green_out, blue_out, alpha_out
//   config    cfg_wr             cfg_addr, cfg_wdata
//
// One pixel enters per clock; busy stays low, so start is always taken.
// The pipeline has 3 front stages, 8 divider stages (2 quotient bits
// each, the 16-bit hue fraction sets this depth), 3 hue stages, 2 tone stages.
// Reset clears the stage valid bits and loads the default settings.
// The receiver cannot stall; each result shows for exactly one cycle on done.
`default_nettype none

module pixel_hue_saturation_adjust
    import phsa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire chan_t            red_in,
    input  wire chan_t            green_in,
    input  wire chan_t            blue_in,
    input  wire chan_t            alpha_in,
    output logic                  done,
    output chan_t                 red_out,
    output chan_t                 green_out,
    output chan_t                 blue_out,
    output chan_t                 alpha_out,
    input  wire logic             cfg_wr,
    input  wire logic [1:0]       cfg_addr,
    input  wire logic [CFG_W-1:0] cfg_wdata
);

    logic signed [GAIN_W-1:0]   contrast_gain_reg;
    logic signed [BRIGHT_W-1:0] brightness_offset_reg;
    logic [HUE_W-1:0]           hue_offset_reg;
    logic signed [SAT_W-1:0]    saturation_gain_reg;

    front_t front;
    quot_t  quot;
    pix_t   rebuilt;
    pix_t   toned;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_gain_reg     <= GAIN_W'(4096);
            brightness_offset_reg <= '0;
            hue_offset_reg        <= '0;
            saturation_gain_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_CONTRAST: contrast_gain_reg     <= cfg_wdata[GAIN_W-1:0];
                CFG_BRIGHT:   brightness_offset_reg <= cfg_wdata[BRIGHT_W-1:0];
                CFG_HUE:      hue_offset_reg        <= cfg_wdata[HUE_W-1:0];
                CFG_SAT:      saturation_gain_reg   <= cfg_wdata[SAT_W-1:0];
                default:      ;
            endcase
        end
    end

    assign busy = 1'b0;

    phsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .r        (red_in),
        .g        (green_in),
        .b        (blue_in),
        .a        (alpha_in),
        .sat_gain (saturation_gain_reg),
        .out      (front)
    );

    phsa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (front),
        .out   (quot)
    );

    phsa_rebuild u_rebuild (
        .clk        (clk),
        .rst_n      (rst_n),
        .in         (quot),
        .hue_offset (hue_offset_reg),
        .out        (rebuilt)
    );

    phsa_tone u_tone (
        .clk               (clk),
        .rst_n             (rst_n),
        .in                (rebuilt),
        .contrast_gain     (contrast_gain_reg),
        .brightness_offset (brightness_offset_reg),
        .out               (toned)
    );

    assign done      = toned.valid;
    assign red_out   = toned.r;
    assign green_out = toned.g;
    assign blue_out  = toned.b;
    assign alpha_out = toned.a;

endmodule

`default_nettype wire
